### sv/sstb_pkg.sv
// ----------------------------------------------------------------------------
// sstb_pkg: shared types and constants of the star box threshold unit
// Widths of the pixel and result words, configuration register indexes,
// the job word passed from the window front end to the result back end.
// ----------------------------------------------------------------------------
package sstb_pkg;

    // default sizes for the line stores and row counter
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 1024;

    // job queue between front end and back end
    localparam int QUEUE_DEPTH = 4;

    // word widths fixed by the interface
    localparam int IN_W       = 5;
    localparam int SUM_W      = 9;
    localparam int THR_W      = 10;
    localparam int LVL_W      = 5;
    localparam int IW_W       = 8;
    localparam int IH_W       = 11;
    localparam int OUT_ROW_W  = 10;
    localparam int OUT_COL_W  = 7;
    localparam int WSUM_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // result slots judged by one pixel, in output order
    localparam int NUM_SLOTS     = 4;
    localparam int SLOT_PREV_PREV = 0;  // previous row, previous column
    localparam int SLOT_PREV_CUR  = 1;  // previous row, current column (row end)
    localparam int SLOT_CUR_PREV  = 2;  // current row, previous column (last row)
    localparam int SLOT_CUR_CUR   = 3;  // current row, current column (last pixel)

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_STAR_LEVEL   = 2'd2
    } t_cfg_idx;

    // one pixel's pending results: which slots exist and their window sums
    typedef struct packed {
        logic [NUM_SLOTS-1:0]            mask;
        logic [NUM_SLOTS-1:0][SUM_W-1:0] sum;
    } t_job;

    // one result word
    typedef struct packed {
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 is_star;
        logic [WSUM_W-1:0]    window_sum;
        logic                 last_of_run;
        logic                 frame_done;
    } t_result;

endpackage

### sv/sstb_ram.sv
// ----------------------------------------------------------------------------
// sstb_ram: generic single write port, single read port RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module sstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sstb_front.sv
// ----------------------------------------------------------------------------
// sstb_front: pixel intake, line stores and 3x3 window
// Tracks the raster position, reads and rewrites the two line stores, shifts
// the window and classifies which neighbourhoods each pixel completes.
// ----------------------------------------------------------------------------
module sstb_front #(
    parameter int MAX_WIDTH  = sstb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sstb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [sstb_pkg::IN_W-1:0] i_intensity,
    input  logic [CW-1:0]             i_wm1,
    input  logic [RW-1:0]             i_hm1,
    input  logic [QCW-1:0]            i_q_count,
    output logic                      o_job_valid,
    output sstb_pkg::t_job            o_job,
    output logic [RW-1:0]             o_job_row,
    output logic [CW-1:0]             o_job_col
);
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QCW = $clog2(sstb_pkg::QUEUE_DEPTH + 1);
    localparam int IW  = sstb_pkg::IN_W;
    localparam int SW  = sstb_pkg::SUM_W;

    // position counters
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // intake stage
    logic          r_s1_valid;
    logic [IW-1:0] r_s1_v;
    logic [CW-1:0] r_s1_c;
    logic [RW-1:0] r_s1_r;
    logic          r_s1_row_end;
    logic          r_s1_last_row;
    logic          r_s1_fwd;
    logic [IW-1:0] r_fwd_near;
    logic [IW-1:0] r_fwd_far;

    // window stage
    logic                          r_s2_valid;
    logic [sstb_pkg::NUM_SLOTS-1:0] r_s2_mask;
    logic [CW-1:0]                 r_s2_c;
    logic [RW-1:0]                 r_s2_r;
    logic [IW-1:0]                 r_win [9];
    logic [IW-1:0]                 n_win [9];

    logic          accept;
    logic [CW-1:0] c_acc;
    logic [RW-1:0] r_acc;
    logic          row_end_acc;
    logic          last_row_acc;
    logic [IW-1:0] near_rd;
    logic [IW-1:0] far_rd;
    logic [IW-1:0] near_raw;
    logic [IW-1:0] far_raw;
    logic [IW-1:0] above1;
    logic [IW-1:0] above2;
    logic [sstb_pkg::NUM_SLOTS-1:0] s1_mask;
    logic [SW-1:0] col_full [3];
    logic [SW-1:0] col_low  [3];

    // credit check: queue words plus words still in flight
    assign o_full = (int'(i_q_count) + int'(r_s1_valid) + int'(r_s2_valid))
                    >= sstb_pkg::QUEUE_DEPTH;
    assign accept = i_push && !o_full;

    // clip the position to the current image size
    always_comb begin
        c_acc        = (r_col > i_wm1) ? i_wm1 : r_col;
        r_acc        = (r_row > i_hm1) ? i_hm1 : r_row;
        row_end_acc  = (c_acc == i_wm1);
        last_row_acc = (r_acc == i_hm1);
    end

    // next position in raster order
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end_acc) begin
                n_col = '0;
                n_row = last_row_acc ? '0 : RW'(r_acc + 1'b1);
            end else begin
                n_col = CW'(c_acc + 1'b1);
                n_row = r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // intake stage registers, with bypass for a back-to-back hit on one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_v        <= i_intensity;
            r_s1_c        <= c_acc;
            r_s1_r        <= r_acc;
            r_s1_row_end  <= row_end_acc;
            r_s1_last_row <= last_row_acc;
            r_s1_fwd      <= r_s1_valid && (c_acc == r_s1_c);
            r_fwd_near    <= r_s1_v;
            r_fwd_far     <= near_raw;
        end
    end

    // line store for the row above
    sstb_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_WIDTH)
    ) u_near_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_c),
        .i_wdata (r_s1_v),
        .i_re    (accept),
        .i_raddr (c_acc),
        .o_rdata (near_rd)
    );

    // line store for two rows above
    sstb_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_WIDTH)
    ) u_far_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_c),
        .i_wdata (near_raw),
        .i_re    (accept),
        .i_raddr (c_acc),
        .o_rdata (far_rd)
    );

    // line store data, masked above the top of the image
    always_comb begin
        near_raw = r_s1_fwd ? r_fwd_near : near_rd;
        far_raw  = r_s1_fwd ? r_fwd_far  : far_rd;
        above1   = (r_s1_r == '0) ? '0 : near_raw;
        above2   = (r_s1_r < RW'(2)) ? '0 : far_raw;
    end

    // window shift: oldest column out, cleared at the row start
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_win[k] = r_win[k];
        end
        if (r_s1_valid) begin
            for (int k = 0; k < 6; k++) begin
                n_win[k] = (r_s1_c == '0) ? '0 : r_win[k+3];
            end
            n_win[6] = above2;
            n_win[7] = above1;
            n_win[8] = r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // which neighbourhoods this pixel completes
    always_comb begin
        s1_mask = '0;
        s1_mask[sstb_pkg::SLOT_PREV_PREV] = (r_s1_r != '0) && (r_s1_c != '0);
        s1_mask[sstb_pkg::SLOT_PREV_CUR]  = (r_s1_r != '0) && r_s1_row_end;
        s1_mask[sstb_pkg::SLOT_CUR_PREV]  = r_s1_last_row && (r_s1_c != '0);
        s1_mask[sstb_pkg::SLOT_CUR_CUR]   = r_s1_last_row && r_s1_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && (s1_mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_mask <= s1_mask;
            r_s2_c    <= r_s1_c;
            r_s2_r    <= r_s1_r;
        end
    end

    // column sums, full height and without the top row
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            col_low[k]  = SW'(r_win[3*k+1]) + SW'(r_win[3*k+2]);
            col_full[k] = col_low[k] + SW'(r_win[3*k]);
        end
    end

    // job word toward the queue
    always_comb begin
        o_job_valid = r_s2_valid;
        o_job.mask  = r_s2_mask;
        o_job.sum[sstb_pkg::SLOT_PREV_PREV] = col_full[0] + col_full[1] + col_full[2];
        o_job.sum[sstb_pkg::SLOT_PREV_CUR]  = col_full[1] + col_full[2];
        o_job.sum[sstb_pkg::SLOT_CUR_PREV]  = col_low[0] + col_low[1] + col_low[2];
        o_job.sum[sstb_pkg::SLOT_CUR_CUR]   = col_low[1] + col_low[2];
        o_job_row   = r_s2_r;
        o_job_col   = r_s2_c;
    end

endmodule

### sv/sstb_queue.sv
// ----------------------------------------------------------------------------
// sstb_queue: short job queue between front end and back end
// Circular buffer with an occupancy count; the head word is always visible.
// ----------------------------------------------------------------------------
module sstb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sstb_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic [QCW-1:0]   o_count
);
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [QCW-1:0]   r_count, n_count;

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wptr + 1'b1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = QCW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = QCW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    // the credit check in the front end must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCW'(DEPTH)))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("job queue underflow");

endmodule

### sv/sstb_back.sv
// ----------------------------------------------------------------------------
// sstb_back: result expansion and output register
// Walks the completed neighbourhoods of the head job one per cycle unless a
// held word waits for pop; it applies the star threshold and saturation.
// ----------------------------------------------------------------------------
module sstb_back #(
    parameter int MAX_WIDTH  = sstb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sstb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_head_valid,
    input  sstb_pkg::t_job             i_job,
    input  logic [RW-1:0]              i_row,
    input  logic [CW-1:0]              i_col,
    input  logic [sstb_pkg::LVL_W-1:0] i_level,
    output logic                       o_q_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output sstb_pkg::t_result          o_result
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NS = sstb_pkg::NUM_SLOTS;
    localparam int SW = sstb_pkg::SUM_W;
    localparam int TW = sstb_pkg::THR_W;

    logic [NS-1:0]     r_done, n_done;
    logic              r_ovalid, n_ovalid;
    sstb_pkg::t_result r_res;

    logic [NS-1:0]     remaining;
    logic [NS-1:0]     sel;
    logic              last;
    logic              advance;
    logic [SW-1:0]     sum_sel;
    logic [TW-1:0]     lvl1;
    logic [TW-1:0]     thr;
    logic [RW-1:0]     orow;
    logic [CW-1:0]     ocol;
    logic [31:0]       orow_ext;
    logic [31:0]       ocol_ext;
    sstb_pkg::t_result res_new;

    // next slot of the head job, lowest first
    always_comb begin
        remaining = i_job.mask & ~r_done;
        sel       = remaining & NS'(~remaining + 1'b1);
        last      = ((remaining & ~sel) == '0);
        advance   = i_head_valid && (!r_ovalid || i_pop);
        o_q_pop   = advance && last;
    end

    // slot bookkeeping
    always_comb begin
        n_done = r_done;
        if (advance) begin
            n_done = last ? '0 : (r_done | sel);
        end
    end

    // sum of the chosen slot and the star threshold 9 * (level + 1)
    always_comb begin
        sum_sel = '0;
        for (int k = 0; k < NS; k++) begin
            if (sel[k]) begin
                sum_sel = sum_sel | i_job.sum[k];
            end
        end
        lvl1 = TW'(i_level) + 1'b1;
        thr  = TW'({lvl1, 3'b000}) + lvl1;
    end

    // position and fields of the new result
    always_comb begin
        orow = (sel[sstb_pkg::SLOT_CUR_PREV] || sel[sstb_pkg::SLOT_CUR_CUR])
               ? i_row : RW'(i_row - 1'b1);
        ocol = (sel[sstb_pkg::SLOT_PREV_CUR] || sel[sstb_pkg::SLOT_CUR_CUR])
               ? i_col : CW'(i_col - 1'b1);
        orow_ext = 32'(orow);
        ocol_ext = 32'(ocol);
        res_new.out_row     = orow_ext[sstb_pkg::OUT_ROW_W-1:0];
        res_new.out_col     = ocol_ext[sstb_pkg::OUT_COL_W-1:0];
        res_new.is_star     = (TW'(sum_sel) >= thr);
        res_new.window_sum  = sum_sel[SW-1] ? '1 : sum_sel[sstb_pkg::WSUM_W-1:0];
        res_new.last_of_run = last;
        res_new.frame_done  = sel[sstb_pkg::SLOT_CUR_CUR];
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid;
        if (advance) begin
            n_ovalid = 1'b1;
        end else if (i_pop) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res_new;
        end
    end

    assign o_empty  = !r_ovalid;
    assign o_result = r_res;

    // the final position of an image is always the last result of its pixel
    a_frame_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_res.frame_done) |-> r_res.last_of_run)
        else $error("frame end result not marked last of run");

    // a partly emitted job stays at the queue head
    a_partial_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done != '0) |-> i_head_valid)
        else $error("partly emitted job lost from queue head");

endmodule

### sv/sky_star_box_threshold_unit.sv
// ----------------------------------------------------------------------------
// sky_star_box_threshold_unit: star finder by 3x3 box sum and threshold
// Raster pixel stream in, one result word per judged position out.
//
//   channel   handshake                 payload
//   pixel     push / full               i_intensity
//   result    empty / pop               o_out_row, o_out_col, o_is_star,
//                                       o_window_sum, o_last_of_run, o_frame_done
//   config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel per clock is taken while full is low; an accepted pixel passes
// the intake and window stage registers on its way into the job queue.
// The back end emits one result word per clock while words are popped, so
// pixels judging two or more positions (row ends, last row) raise full.
// Reset is synchronous; line stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module sky_star_box_threshold_unit #(
    parameter int MAX_WIDTH  = sstb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sstb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input
    input  logic                            push,
    output logic                            full,
    input  logic [sstb_pkg::IN_W-1:0]       i_intensity,
    // result output
    output logic                            empty,
    input  logic                            pop,
    output logic [sstb_pkg::OUT_ROW_W-1:0]  o_out_row,
    output logic [sstb_pkg::OUT_COL_W-1:0]  o_out_col,
    output logic                            o_is_star,
    output logic [sstb_pkg::WSUM_W-1:0]     o_window_sum,
    output logic                            o_last_of_run,
    output logic                            o_frame_done,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sstb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sstb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QCW = $clog2(sstb_pkg::QUEUE_DEPTH + 1);
    localparam int JW  = $bits(sstb_pkg::t_job);
    localparam int QW  = RW + CW + JW;

    logic [sstb_pkg::IW_W-1:0]  r_image_width;
    logic [sstb_pkg::IH_W-1:0]  r_image_height;
    logic [sstb_pkg::LVL_W-1:0] r_star_level;

    logic [31:0]        wm1_full;
    logic [31:0]        hm1_full;
    logic [CW-1:0]      wm1;
    logic [RW-1:0]      hm1;
    logic [QCW-1:0]     q_count;
    logic               job_valid;
    sstb_pkg::t_job     job_in;
    logic [RW-1:0]      job_row_in;
    logic [CW-1:0]      job_col_in;
    logic [QW-1:0]      q_head;
    sstb_pkg::t_job     job_head;
    logic [RW-1:0]      job_row_head;
    logic [CW-1:0]      job_col_head;
    logic               q_pop;
    sstb_pkg::t_result  result;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sstb_pkg::IW_W'(30);
            r_image_height <= sstb_pkg::IH_W'(10);
            r_star_level   <= sstb_pkg::LVL_W'(10);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sstb_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[sstb_pkg::IW_W-1:0];
                end
                sstb_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[sstb_pkg::IH_W-1:0];
                end
                sstb_pkg::CFG_STAR_LEVEL: begin
                    r_star_level <= i_cfg_data[sstb_pkg::LVL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // last column and row, size clipped to 1..max
    always_comb begin
        if (r_image_width == '0) begin
            wm1_full = '0;
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            wm1_full = 32'(MAX_WIDTH - 1);
        end else begin
            wm1_full = 32'(r_image_width) - 32'd1;
        end
        if (r_image_height == '0) begin
            hm1_full = '0;
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            hm1_full = 32'(MAX_HEIGHT - 1);
        end else begin
            hm1_full = 32'(r_image_height) - 32'd1;
        end
        wm1 = wm1_full[CW-1:0];
        hm1 = hm1_full[RW-1:0];
    end

    // front end: position, line stores, window
    sstb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_intensity (i_intensity),
        .i_wm1       (wm1),
        .i_hm1       (hm1),
        .i_q_count   (q_count),
        .o_job_valid (job_valid),
        .o_job       (job_in),
        .o_job_row   (job_row_in),
        .o_job_col   (job_col_in)
    );

    // job queue
    sstb_queue #(
        .WIDTH (QW),
        .DEPTH (sstb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  ({job_row_in, job_col_in, job_in}),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_count (q_count)
    );

    assign job_row_head = q_head[QW-1 -: RW];
    assign job_col_head = q_head[JW+CW-1 -: CW];
    assign job_head     = q_head[JW-1:0];

    // back end: result expansion
    sstb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_count != '0),
        .i_job        (job_head),
        .i_row        (job_row_head),
        .i_col        (job_col_head),
        .i_level      (r_star_level),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (result)
    );

    assign o_out_row     = result.out_row;
    assign o_out_col     = result.out_col;
    assign o_is_star     = result.is_star;
    assign o_window_sum  = result.window_sum;
    assign o_last_of_run = result.last_of_run;
    assign o_frame_done  = result.frame_done;

endmodule

### verif/star_box_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_box_checker: result prediction and comparison for the star box unit
// Follows register writes and accepted pixels, and predicts every judged
// position with its clipped 3x3 sum, star flag and end-of-run/frame flags.
// Each popped word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module star_box_checker #(
    parameter int MAX_WIDTH  = sstb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sstb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel channel
    input  logic                            i_push,
    input  logic                            i_full,
    input  logic [sstb_pkg::IN_W-1:0]       i_intensity,
    // result channel
    input  logic                            i_empty,
    input  logic                            i_pop,
    input  logic [sstb_pkg::OUT_ROW_W-1:0]  i_out_row,
    input  logic [sstb_pkg::OUT_COL_W-1:0]  i_out_col,
    input  logic                            i_is_star,
    input  logic [sstb_pkg::WSUM_W-1:0]     i_window_sum,
    input  logic                            i_last_of_run,
    input  logic                            i_frame_done,
    // register write channel
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [sstb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sstb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // status toward the testbench top
    output int                              o_pending,
    output int                              o_fail_count
);
    import sstb_pkg::*;

    localparam int WIDTH_AT_RESET  = 30;
    localparam int HEIGHT_AT_RESET = 10;
    localparam int LEVEL_AT_RESET  = 10;
    localparam int BOX_DIVISOR     = 9;
    localparam int SUM_CEILING     = 255;

    // predictor copy of the registers and the image state
    logic [IW_W-1:0]  width_q;
    logic [IH_W-1:0]  height_q;
    logic [LVL_W-1:0] level_q;
    logic [IN_W-1:0]  row_mem [0:2*MAX_WIDTH-1];
    logic [IN_W-1:0]  box [0:8];
    int               row_q;
    int               col_q;

    t_result judged_marks [$];
    t_result oldest_mark;
    int      fails = 0;

    // predict the positions judged by one pixel and queue them in order
    task automatic judge_pixel(input logic [IN_W-1:0] px);
        int w, h, r, c, n, s, k, rs, cs, bc, br, orow, ocol;
        logic [IN_W-1:0] two_up, one_up;
        logic row_end, last_row;
        t_result marks [0:3];
        w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : int'(width_q));
        h = (height_q == 0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q));
        c = (col_q > w - 1) ? w - 1 : col_q;
        r = (row_q > h - 1) ? h - 1 : row_q;
        row_end  = (c == w - 1);
        last_row = (r == h - 1);

        // line stores shift down by one row at this column
        two_up = row_mem[MAX_WIDTH + c];
        one_up = row_mem[c];
        row_mem[MAX_WIDTH + c] = one_up;
        row_mem[c] = px;
        if (r < 2) two_up = '0;
        if (r < 1) one_up = '0;

        // window slides left; a new row starts with empty columns
        for (k = 0; k < 6; k++) box[k] = (c == 0) ? '0 : box[k + 3];
        box[6] = two_up;
        box[7] = one_up;
        box[8] = px;

        n = 0;
        for (rs = 0; rs < 2; rs++) begin
            for (cs = 0; cs < 2; cs++) begin
                if ((rs == 0 && r < 1) || (rs == 1 && !last_row)) continue;
                if ((cs == 0 && c < 1) || (cs == 1 && !row_end)) continue;
                s = 0;
                for (bc = (cs == 0) ? 0 : 1; bc < 3; bc++)
                    for (br = (rs == 0) ? 0 : 1; br < 3; br++)
                        s += box[bc * 3 + br];
                orow = (rs == 0) ? r - 1 : r;
                ocol = (cs == 0) ? c - 1 : c;
                marks[n].out_row     = orow[OUT_ROW_W-1:0];
                marks[n].out_col     = ocol[OUT_COL_W-1:0];
                marks[n].is_star     = (s / BOX_DIVISOR > int'(level_q));
                marks[n].window_sum  = (s > SUM_CEILING) ? SUM_CEILING : s[WSUM_W-1:0];
                marks[n].last_of_run = 1'b0;
                marks[n].frame_done  = (orow == h - 1 && ocol == w - 1);
                n++;
            end
        end
        if (n > 0) marks[n - 1].last_of_run = 1'b1;
        for (k = 0; k < n; k++) judged_marks.push_back(marks[k]);

        // advance the raster position
        if (row_end) begin
            col_q = 0;
            row_q = last_row ? 0 : r + 1;
        end else begin
            col_q = c + 1;
            row_q = r;
        end
    endtask

    // follow the three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_q  = WIDTH_AT_RESET;
            height_q = HEIGHT_AT_RESET;
            level_q  = LEVEL_AT_RESET;
            for (int k = 0; k < 9; k++) box[k] = '0;
            row_q = 0;
            col_q = 0;
            judged_marks.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  width_q  = i_cfg_data[IW_W-1:0];
                    CFG_IMAGE_HEIGHT: height_q = i_cfg_data[IH_W-1:0];
                    CFG_STAR_LEVEL:   level_q  = i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end

            // popped result word against the oldest prediction
            if (i_pop && !i_empty) begin
                if (judged_marks.size() == 0) begin
                    $error("result word row %0d col %0d with no prediction waiting",
                           i_out_row, i_out_col);
                    fails++;
                end else begin
                    oldest_mark = judged_marks.pop_front();
                    if (i_out_row !== oldest_mark.out_row) begin
                        $error("out_row expected %0d actual %0d", oldest_mark.out_row, i_out_row);
                        fails++;
                    end
                    if (i_out_col !== oldest_mark.out_col) begin
                        $error("out_col expected %0d actual %0d", oldest_mark.out_col, i_out_col);
                        fails++;
                    end
                    if (i_is_star !== oldest_mark.is_star) begin
                        $error("is_star expected %0d actual %0d", oldest_mark.is_star, i_is_star);
                        fails++;
                    end
                    if (i_window_sum !== oldest_mark.window_sum) begin
                        $error("window_sum expected %0d actual %0d",
                               oldest_mark.window_sum, i_window_sum);
                        fails++;
                    end
                    if (i_last_of_run !== oldest_mark.last_of_run) begin
                        $error("last_of_run expected %0d actual %0d",
                               oldest_mark.last_of_run, i_last_of_run);
                        fails++;
                    end
                    if (i_frame_done !== oldest_mark.frame_done) begin
                        $error("frame_done expected %0d actual %0d",
                               oldest_mark.frame_done, i_frame_done);
                        fails++;
                    end
                end
            end

            // accepted pixel
            if (i_push && !i_full) judge_pixel(i_intensity);
        end
        o_pending    <= judged_marks.size();
        o_fail_count <= fails;
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pixel stream test of the star box threshold unit
// Short directed images cover reset sizes, sizes of zero and above the
// maximum, mid-image size changes, saturated sums and unreachable levels;
// then random images of random size and level, with bursty pixel pushes,
// a patterned result drain and one long drain hold that backs up the block.
// ----------------------------------------------------------------------------
module testbench;
    import sstb_pkg::*;

    localparam int STALL_LIMIT    = 1000;   // well above hold + gaps + latency
    localparam int SQUEEZE_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 8;      // pixel-to-result latency with margin
    localparam int PIXEL_BUDGET   = 470;

    // register select masks for cfg_write
    localparam logic [2:0] WR_WIDTH  = 3'b001 << CFG_IMAGE_WIDTH;
    localparam logic [2:0] WR_HEIGHT = 3'b001 << CFG_IMAGE_HEIGHT;
    localparam logic [2:0] WR_LEVEL  = 3'b001 << CFG_STAR_LEVEL;
    localparam logic [2:0] WR_ALL    = WR_WIDTH | WR_HEIGHT | WR_LEVEL;

    typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SPARSE, DRAIN_BEAT} t_drain_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [IN_W-1:0]       i_intensity;
    logic                  empty;
    logic                  pop;
    logic [OUT_ROW_W-1:0]  o_out_row;
    logic [OUT_COL_W-1:0]  o_out_col;
    logic                  o_is_star;
    logic [WSUM_W-1:0]     o_window_sum;
    logic                  o_last_of_run;
    logic                  o_frame_done;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   marks_pending;
    int   fail_count;
    int   pixels_sent = 0;
    int   burst_left  = 1;
    int   stall_cycles = 0;
    logic squeeze_req;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sky_star_box_threshold_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_intensity  (i_intensity),
        .empty        (empty),
        .pop          (pop),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_is_star    (o_is_star),
        .o_window_sum (o_window_sum),
        .o_last_of_run(o_last_of_run),
        .o_frame_done (o_frame_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    star_box_checker u_star_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_intensity  (i_intensity),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_is_star    (o_is_star),
        .i_window_sum (o_window_sum),
        .i_last_of_run(o_last_of_run),
        .i_frame_done (o_frame_done),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (marks_pending),
        .o_fail_count (fail_count)
    );

    // mostly legal intensities, now and then above 20
    function automatic logic [IN_W-1:0] draw_intensity();
        if ($urandom_range(0, 15) == 0) return IN_W'($urandom_range(21, 31));
        return IN_W'($urandom_range(0, 20));
    endfunction

    // offer one pixel word, then maybe pause between bursts
    task automatic send_pixel(input logic [IN_W-1:0] px);
        int gap;
        push        <= 1'b1;
        i_intensity <= px;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pixels_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_image(input int count);
        int k;
        for (k = 0; k < count; k++) send_pixel(draw_intensity());
    endtask

    // let every predicted word drain, then cover pixels still in flight
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (marks_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // write the selected registers back to back, valid held between them
    task automatic cfg_write(input logic [2:0] sel, input int unsigned wv, hv, lv);
        if (sel & WR_WIDTH)  cfg_put(CFG_IMAGE_WIDTH, wv);
        if (sel & WR_HEIGHT) cfg_put(CFG_IMAGE_HEIGHT, hv);
        if (sel & WR_LEVEL)  cfg_put(CFG_STAR_LEVEL, lv);
        i_cfg_valid <= 1'b0;
    endtask

    // pixel stimulus and verdict
    initial begin : pixel_source
        int unsigned w, h, lvl, npix, part;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_intensity <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= '0;
        squeeze_req <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: start a 30 wide row, then cut height and width mid-row
        repeat (3) send_pixel(5'd31);
        settle();
        cfg_write(WR_HEIGHT, 0, 0, 0);
        send_pixel(5'd31);
        settle();
        cfg_write(WR_WIDTH, 3, 0, 0);
        send_pixel(5'd20);
        settle();

        // width zero, height beyond max, then height zero in the middle
        cfg_write(WR_ALL, 0, 2047, 0);
        send_pixel(5'd0);
        send_pixel(5'd31);
        settle();
        cfg_write(WR_HEIGHT, 0, 0, 0);
        send_pixel(5'd20);
        settle();

        // saturated window sum that still makes a star
        cfg_write(WR_ALL, 3, 3, 20);
        repeat (9) send_pixel(5'd31);
        settle();

        // level 31 is never exceeded
        cfg_write(WR_HEIGHT | WR_LEVEL, 0, 1, 31);
        send_pixel(5'd31);
        send_pixel(5'd0);
        send_pixel(5'd20);
        settle();

        // widest row, first beyond max then at max, with a long drain hold
        cfg_write(WR_ALL, 255, 1, $urandom_range(0, 4));
        squeeze_req <= 1'b1;
        send_image(64);
        settle();
        cfg_write(WR_WIDTH, 128, 0, 0);
        send_image(64);
        settle();

        // random images, sometimes with a level change part way through
        while (pixels_sent < PIXEL_BUDGET) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            lvl = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 31) : $urandom_range(0, 20);
            cfg_write(WR_ALL, w, h, lvl);
            npix = w * h;
            if ($urandom_range(0, 3) == 0) begin
                part = $urandom_range(1, npix);
                send_image(part);
                settle();
                cfg_write(WR_LEVEL, 0, 0, $urandom_range(0, 20));
                npix = npix - part;
            end
            send_image(npix);
            settle();
        end

        if (fail_count == 0 && marks_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // result drain: random patterns per stretch, one long hold on request
    initial begin : result_sink
        t_drain_mode mode;
        int span, k;
        logic held;
        held = 1'b0;
        pop <= 1'b0;
        forever begin
            mode = t_drain_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (squeeze_req && !held) begin
                    held = 1'b1;
                    pop <= 1'b0;
                    repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    DRAIN_FREE:   pop <= 1'b1;
                    DRAIN_COIN:   pop <= ($urandom_range(0, 1) == 1);
                    DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                    default:      pop <= ((k % 8) < 5);
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
